[rtl/core/chbd_pkg.sv]
// ----------------------------------------------------------------------------
// chbd_pkg: shared types and constants of the chunked body decoder
// Item layouts on both channels, the classified item carried between the
// front and back parts, queue status and the result status codes.
// ----------------------------------------------------------------------------
package chbd_pkg;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;

  // Input item as it arrives from the link.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_body;
    logic       end_of_input;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       has_data;
    logic       is_last;
    logic [1:0] status;
  } out_item_t;

  // Input item after classification by the front part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_body;
    logic       end_of_input;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } cls_item_t;

  // Queue status seen by the front and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/chbd_front.sv]
// ----------------------------------------------------------------------------
// chbd_front: input acceptance and byte classification
// Accepts an item whenever the queue has room and tags the byte as hex
// digit (with its value), CR or LF before it is queued.
// ----------------------------------------------------------------------------
module chbd_front
  import chbd_pkg::*;
(
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  q_stat_t   q_stat,
  output logic      push,
  output cls_item_t push_item
);

  // Decode one ASCII hex digit; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, 4'(c - 8'h37)};
    end
    return res;
  endfunction

  logic [4:0] hex;

  // The input is held off only while the queue is full.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify the byte.
  assign hex = hex_decode(in_item.data_byte);
  always_comb begin
    push_item.data_byte     = in_item.data_byte;
    push_item.start_of_body = in_item.start_of_body;
    push_item.end_of_input  = in_item.end_of_input;
    push_item.is_hex        = hex[4];
    push_item.hex_val       = hex[3:0];
    push_item.is_cr         = (in_item.data_byte == 8'h0D);
    push_item.is_lf         = (in_item.data_byte == 8'h0A);
  end

endmodule

[rtl/core/chbd_queue.sv]
// ----------------------------------------------------------------------------
// chbd_queue: short queue between the front and back parts
// A small circular buffer of classified items with head read-out, so that
// the input side and the result side can stall independently.
// ----------------------------------------------------------------------------
module chbd_queue
  import chbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  input  logic      pop,
  output cls_item_t head_item,
  output q_stat_t   q_stat
);

  cls_item_t         mem [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]      count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

[rtl/core/chbd_back.sv]
// ----------------------------------------------------------------------------
// chbd_back: chunk parser and result register
// Runs the size-line / data / trailer-skip state machine on one queued item
// per cycle unless a held result is stalled; holds the result until taken.
// ----------------------------------------------------------------------------
module chbd_back
  import chbd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cls_item_t head_item,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(MAX_HEX_DIGITS + 1);

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_SKIP1,
    PH_SKIP2,
    PH_IDLE
  } phase_t;

  phase_t          phase_r, phase_nxt, phase_cur;
  logic [31:0]     rem_r, rem_nxt, rem_cur;
  logic [CW-1:0]   cnt_r, cnt_nxt, cnt_cur;
  logic            stopped_r, stopped_nxt, stopped_cur;
  logic            saw_cr_r, saw_cr_nxt, saw_cr_cur;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;
  logic            produce;
  out_item_t       res;

  // Take the head item when the result register is free or being emptied.
  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  // Parser step for the head item.
  always_comb begin
    // Start of body restarts the size line.
    if (head_item.start_of_body) begin
      phase_cur   = PH_SIZE;
      rem_cur     = '0;
      cnt_cur     = '0;
      stopped_cur = 1'b0;
      saw_cr_cur  = 1'b0;
    end else begin
      phase_cur   = phase_r;
      rem_cur     = rem_r;
      cnt_cur     = cnt_r;
      stopped_cur = stopped_r;
      saw_cr_cur  = saw_cr_r;
    end

    phase_nxt   = phase_cur;
    rem_nxt     = rem_cur;
    cnt_nxt     = cnt_cur;
    stopped_nxt = stopped_cur;
    saw_cr_nxt  = saw_cr_cur;
    produce     = 1'b0;
    res         = '{body_byte: 8'd0, has_data: 1'b0, is_last: 1'b0, status: ST_OK};

    unique case (phase_cur)
      PH_SIZE: begin
        if (head_item.is_lf && saw_cr_cur) begin
          saw_cr_nxt = 1'b0;
          if (rem_cur == '0) begin
            produce     = 1'b1;
            res.is_last = 1'b1;
            phase_nxt   = PH_IDLE;
          end else begin
            phase_nxt = PH_DATA;
          end
        end else if (head_item.is_cr) begin
          saw_cr_nxt  = 1'b1;
          stopped_nxt = 1'b1;
        end else begin
          saw_cr_nxt = 1'b0;
          if (head_item.is_hex && !stopped_cur) begin
            if (cnt_cur >= CW'(MAX_HEX_DIGITS)) begin
              produce     = 1'b1;
              res.is_last = 1'b1;
              res.status  = ST_TOO_LONG;
              phase_nxt   = PH_IDLE;
            end else begin
              cnt_nxt = cnt_cur + 1'b1;
              rem_nxt = {rem_cur[27:0], head_item.hex_val};
            end
          end else begin
            stopped_nxt = 1'b1;
          end
        end
      end
      PH_DATA: begin
        produce       = 1'b1;
        res.body_byte = head_item.data_byte;
        res.has_data  = 1'b1;
        rem_nxt       = rem_cur - 32'd1;
        if (rem_cur == 32'd1) begin
          phase_nxt = PH_SKIP1;
        end
      end
      PH_SKIP1: begin
        phase_nxt = PH_SKIP2;
      end
      PH_SKIP2: begin
        phase_nxt   = PH_SIZE;
        rem_nxt     = '0;
        cnt_nxt     = '0;
        stopped_nxt = 1'b0;
        saw_cr_nxt  = 1'b0;
      end
      PH_IDLE: begin
        // Bytes are dropped until the next start of body.
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // Link ran out before the body finished.
    if (head_item.end_of_input && phase_cur != PH_IDLE && phase_nxt != PH_IDLE) begin
      produce     = 1'b1;
      res.is_last = 1'b1;
      res.status  = ST_EARLY_END;
      phase_nxt   = PH_IDLE;
    end
  end

  // Result register next value.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && produce) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end
  end

  // Parser state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIZE;
      rem_r       <= '0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      saw_cr_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r   <= phase_nxt;
        rem_r     <= rem_nxt;
        cnt_r     <= cnt_nxt;
        stopped_r <= stopped_nxt;
        saw_cr_r  <= saw_cr_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/core/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked body decoder, one byte per item
// Path: an accepted byte goes through the queue into the result register.
// Throughput: one item per cycle, paced by the back parser and by out_stall.
// The front stalls only when the four-entry queue is full.
// Reset: synchronous active-low; empties the queue and the result register
// and puts the parser at the first character of a size line.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
  import chbd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      push;
  logic      pop;
  cls_item_t push_item;
  cls_item_t head_item;
  q_stat_t   q_stat;

  // Acceptance and classification.
  chbd_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue between the two parts.
  chbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // Parser and result register.
  chbd_back #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // A result without data always closes the body.
  a_nodata_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.has_data |-> out_item.is_last)
    else $error("result without data is not marked last");

  // Any error status closes the body.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.is_last)
    else $error("error status on a result not marked last");

  // No result can appear when nothing is queued or arriving.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty && !out_valid |=> !out_valid)
    else $error("result appeared with an empty queue");

  // Status stays within its defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_TOO_LONG ||
                   out_item.status == ST_EARLY_END))
    else $error("undefined status code");

endmodule

[bench/http_chunked_body_decoder_tb.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb: self-checking bench for the chunked decoder
// Feeds response bodies one byte per item. A short table of hand-made bodies
// comes first, then random bodies, mostly well formed, with some that are
// broken. A table row or a behavioral decoder predicts each result; they are
// compared in order while both sides of the block pause at random.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
  import chbd_pkg::*;

  localparam int          DIGIT_LIMIT  = 8;
  localparam int          BYTE_TARGET  = 1650;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [7:0]  CR           = 8'h0D;
  localparam logic [7:0]  LF           = 8'h0A;

  // Parser phases of the behavioral decoder.
  typedef enum logic [2:0] {
    SZ_LINE,
    BODY_DATA,
    TRAIL1,
    TRAIL2,
    DONE
  } dec_phase_t;

  // One row of the hand-made table: the byte and, where obvious, its result.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  localparam out_item_t NO_RES    = '0;
  localparam out_item_t END_OK    = '{8'h00, 1'b0, 1'b1, ST_OK};
  localparam out_item_t END_LONG  = '{8'h00, 1'b0, 1'b1, ST_TOO_LONG};
  localparam out_item_t END_EARLY = '{8'h00, 1'b0, 1'b1, ST_EARLY_END};

  localparam dir_row_t DIR_ROWS [0:25] = '{
    // Zero-size line ends the body.
    '{'{"0", 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{CR,  1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{LF,  1'b0, 1'b0}, 1'b1, END_OK},
    // Nine digits: the ninth one aborts the body.
    '{'{"F", 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{"a", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"9", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"0", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"A", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"f", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"0", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"0", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"1", 1'b0, 1'b0}, 1'b1, END_LONG},
    // End of input while idle is ignored.
    '{'{"5", 1'b0, 1'b1}, 1'b0, NO_RES},
    // Size 2 with a lone CR and an extension, two data bytes, free trailer.
    '{'{"2", 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{CR,  1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{";", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{CR,  1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{LF,  1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"x", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"y", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"0", 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{CR,  1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{LF,  1'b0, 1'b0}, 1'b1, END_OK},
    // Input ends in the middle of a size line.
    '{'{"A", 1'b1, 1'b1}, 1'b1, END_EARLY}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Behavioral decoder state.
  dec_phase_t  phase;
  logic [31:0] remaining;
  int          ndigits;
  bit          stopped;
  bit          cr_seen;

  out_item_t decoded_q [$];
  in_item_t  pending [$];
  bit        sob_pending;
  int        in_gap_max;
  int        out_gap_max;
  int        live_cnt;
  int        fail_cnt;
  int        cycle_cnt;
  int        hold;

  http_chunked_body_decoder #(
    .MAX_HEX_DIGITS(DIGIT_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hex digit value, or -1 for any other character.
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void restart_line();
    phase     = SZ_LINE;
    remaining = '0;
    ndigits   = 0;
    stopped   = 1'b0;
    cr_seen   = 1'b0;
  endfunction

  // Advances the decoder by one byte; returns 1 when the byte gives a result.
  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    int v;
    bit hit;
    hit = 1'b0;
    res = '0;
    if (it.start_of_body) restart_line();
    case (phase)
      SZ_LINE: begin
        v = hex_digit(it.data_byte);
        if (it.data_byte == LF && cr_seen) begin
          cr_seen = 1'b0;
          if (remaining == 0) begin
            hit         = 1'b1;
            res.is_last = 1'b1;
            phase       = DONE;
          end else begin
            phase = BODY_DATA;
          end
        end else if (it.data_byte == CR) begin
          cr_seen = 1'b1;
          stopped = 1'b1;
        end else begin
          cr_seen = 1'b0;
          if (v >= 0 && !stopped) begin
            if (ndigits >= DIGIT_LIMIT) begin
              hit         = 1'b1;
              res.is_last = 1'b1;
              res.status  = ST_TOO_LONG;
              phase       = DONE;
            end else begin
              ndigits++;
              remaining = {remaining[27:0], v[3:0]};
            end
          end else begin
            stopped = 1'b1;
          end
        end
      end
      BODY_DATA: begin
        hit           = 1'b1;
        res.body_byte = it.data_byte;
        res.has_data  = 1'b1;
        remaining     = remaining - 1;
        if (remaining == 0) phase = TRAIL1;
      end
      TRAIL1: phase = TRAIL2;
      TRAIL2: restart_line();
      default: return 1'b0;
    endcase
    if (it.end_of_input && phase != DONE) begin
      hit         = 1'b1;
      res.is_last = 1'b1;
      res.status  = ST_EARLY_END;
      phase       = DONE;
    end
    return hit;
  endfunction

  // Offers one item, waits for it to be taken and records its result.
  task automatic send_byte(input in_item_t it, input bit typed, input out_item_t typed_res);
    int        gap;
    bit        live;
    bit        hit;
    out_item_t res;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    live = it.start_of_body || (phase != DONE);
    hit  = decode_byte(it, res);
    if (typed) begin
      decoded_q.push_back(typed_res);
    end else if (hit) begin
      decoded_q.push_back(res);
    end
    if (live) live_cnt++;
  endtask

  // Hex character for a value, either case at random for letters.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return "0" + v;
    return (($urandom_range(0, 1) == 1) ? "A" : "a") + 8'(v - 4'd10);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending.push_back('{b, sob_pending, 1'b0});
    sob_pending = 1'b0;
  endtask

  task automatic push_crlf();
    push_byte(CR);
    push_byte(LF);
  endtask

  // Flags end of input on one queued byte and drops what follows it.
  task automatic cut_at(input int idx);
    in_item_t tmp;
    tmp              = pending[idx];
    tmp.end_of_input = 1'b1;
    pending[idx]     = tmp;
    while (pending.size() > idx + 1) void'(pending.pop_back());
  endtask

  // One chunk: size line with optional decorations, data, two trailer bytes.
  task automatic push_chunk();
    logic [7:0] sz;
    int         lead;
    sz   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(1, 6));
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    repeat (lead) push_byte("0");
    if (sz > 15) push_byte(hex_char(sz[7:4]));
    push_byte(hex_char(sz[3:0]));
    case ($urandom_range(0, 5))
      0: begin
        push_byte(";");
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(32, 126)));
      end
      1: begin
        push_byte(CR);
        push_byte(8'($urandom_range(32, 126)));
      end
      2: push_byte(" ");
      default: ;
    endcase
    push_crlf();
    repeat (sz) push_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) begin
      push_byte(8'($urandom_range(0, 255)));
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_crlf();
    end
  endtask

  // Line that ends the body: zeros, empty, non-hex text or zero with extension.
  task automatic push_terminator();
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 3)) push_byte("0");
      1: ;
      2: push_byte(8'("g" + $urandom_range(0, 10)));
      default: begin
        push_byte("0");
        push_byte(";");
        push_byte(8'($urandom_range(32, 126)));
      end
    endcase
    push_crlf();
  endtask

  // Builds one random body in the pending queue.
  task automatic gen_body();
    int          kind;
    int          d;
    logic [31:0] wide;
    kind        = $urandom_range(0, 19);
    sob_pending = 1'b1;
    if (kind == 0) begin
      // Line noise, sometimes without a start flag.
      sob_pending = ($urandom_range(0, 1) == 1);
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      // Size line with too many digits.
      repeat ($urandom_range(9, 11)) push_byte(hex_char(4'($urandom_range(0, 15))));
      push_crlf();
    end else if (kind == 2) begin
      // Full-width size, cut short by end of input inside the data.
      wide = $urandom();
      for (d = 7; d >= 0; d--) push_byte(hex_char(wide[d*4 +: 4]));
      push_crlf();
      repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
      cut_at(pending.size() - 1);
    end else begin
      repeat ($urandom_range(0, 3)) push_chunk();
      push_terminator();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
      if (kind <= 5) begin
        cut_at($urandom_range(0, pending.size() - 1));
      end else if (kind == 6) begin
        cut_at(pending.size() - 1);
      end
    end
  endtask

  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    fail_cnt++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  // Compares one taken result with the oldest prediction.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
      return;
    end
    want = decoded_q.pop_front();
    if (got.body_byte !== want.body_byte) begin
      report_field("body_byte", want.body_byte, got.body_byte);
    end
    if (got.has_data !== want.has_data) begin
      report_field("has_data", 8'(want.has_data), 8'(got.has_data));
    end
    if (got.is_last !== want.is_last) begin
      report_field("is_last", 8'(want.is_last), 8'(got.is_last));
    end
    if (got.status !== want.status) begin
      report_field("status", 8'(want.status), 8'(got.status));
    end
  endtask

  // Result side: takes items and stalls for a random count after each one.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_item);
        hold = $urandom_range(0, out_gap_max);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Picks how hard each side pauses for the next stretch of items.
  task automatic pick_pacing();
    case ($urandom_range(0, 3))
      0: in_gap_max = 0;
      1: in_gap_max = 16;
      default: in_gap_max = $urandom_range(0, 4);
    endcase
    case ($urandom_range(0, 3))
      0: out_gap_max = 0;
      1: out_gap_max = 16;
      default: out_gap_max = $urandom_range(0, 4);
    endcase
  endtask

  // Reset, table, random bodies, drain and verdict.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    live_cnt    = 0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    hold        = 0;
    in_gap_max  = 0;
    out_gap_max = 0;
    restart_line();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (i % 8 == 0) pick_pacing();
      send_byte(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    while (live_cnt < BYTE_TARGET) begin
      if ($urandom_range(0, 3) == 0) pick_pacing();
      pending.delete();
      gen_body();
      foreach (pending[k]) send_byte(pending[k], 1'b0, NO_RES);
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
